// ===== rtl/substring_matcher_case_fold_defines.svh =====
// ----------------------------------------------------------------------------
// substring matcher assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef SUBSTRING_MATCHER_CASE_FOLD_DEFINES_SVH
`define SUBSTRING_MATCHER_CASE_FOLD_DEFINES_SVH

// condition must hold at every edge outside reset
`define SMCF_ASSERT_ALWAYS(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("smcf checker: invariant violated");

// trigger implies outcome on the following edge
`define SMCF_ASSERT_NEXT(lbl, clk, rst_n, trig, outcome) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (outcome)) \
        else $error("smcf checker: sequence violated");

`endif

// ===== rtl/smcf_pkg.sv =====
// ----------------------------------------------------------------------------
// smcf_pkg
// shared constants, types and fold function for the substring matcher
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package smcf_pkg;

    localparam int UNIT_W            = 16;
    localparam int NEEDLE_MAX_DEF    = 16;
    localparam int POSITION_BITS_DEF = 16;
    localparam int NEEDLE_WORDS      = 4;
    localparam int UNITS_PER_WORD    = 4;
    localparam int CFG_DATA_W        = 64;
    localparam int CFG_INDEX_W       = 3;
    localparam int LEN_W             = 5;
    localparam int OUT_POS_W         = 16;
    localparam int M_TDATA_W         = 40;
    localparam int M_FIELDS_W        = 2 + 2 * OUT_POS_W;

    localparam logic [UNIT_W-1:0] DOUBLE_BYTE_BASE = 16'h8000;
    localparam logic [UNIT_W-1:0] ASCII_UPPER_A    = 16'h0041;
    localparam logic [UNIT_W-1:0] ASCII_UPPER_Z    = 16'h005A;
    localparam logic [UNIT_W-1:0] ASCII_CASE_STEP  = 16'h0020;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_NEEDLE_WORD_0 = 3'd0,
        CFG_NEEDLE_WORD_1 = 3'd1,
        CFG_NEEDLE_WORD_2 = 3'd2,
        CFG_NEEDLE_WORD_3 = 3'd3,
        CFG_NEEDLE_LENGTH = 3'd4,
        CFG_CASE_FOLD     = 3'd5
    } cfg_index_t;

    // per-cycle control shared by every cell of the chain
    typedef struct packed {
        logic advance;
        logic case_fold;
    } cell_ctrl_t;

    // map ascii upper case to lower; double-byte codes pass untouched
    function automatic logic [UNIT_W-1:0] fold_unit(input logic [UNIT_W-1:0] u,
                                                     input logic en);
        logic [UNIT_W-1:0] r;
        r = u;
        if (en && (u < DOUBLE_BYTE_BASE) && (u inside {[ASCII_UPPER_A:ASCII_UPPER_Z]}))
        begin
            r = u + ASCII_CASE_STEP;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/smcf_cell.sv =====
// ----------------------------------------------------------------------------
// smcf_cell
// one window position: compares the unit it receives with its pattern unit and holds that unit
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module smcf_cell (
    input  wire                            clk,
    input  wire                            rst_n,
    input  wire smcf_pkg::cell_ctrl_t      ctrl,
    input  wire  [smcf_pkg::UNIT_W-1:0]    unit_in,
    input  wire  [smcf_pkg::UNIT_W-1:0]    pattern_unit,
    output logic [smcf_pkg::UNIT_W-1:0]    unit_reg,
    output logic                           hit
);

    logic [smcf_pkg::UNIT_W-1:0] unit_folded;
    logic [smcf_pkg::UNIT_W-1:0] pattern_folded;

    assign unit_folded    = smcf_pkg::fold_unit(unit_in, ctrl.case_fold);
    assign pattern_folded = smcf_pkg::fold_unit(pattern_unit, ctrl.case_fold);

    // window unit at this position equals its aligned pattern unit
    assign hit = (unit_folded == pattern_folded);

    // raw unit moves on to the next position with every request
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_reg <= '0;
        end
        else if (ctrl.advance)
        begin
            unit_reg <= unit_in;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/substring_matcher_case_fold.sv =====
// ----------------------------------------------------------------------------
// substring_matcher_case_fold
// streaming substring search over 16-bit code units with optional case fold
// ----------------------------------------------------------------------------
//  channel   | direction | contents
//  ----------+-----------+-------------------------------------------------
//  s_axis    | in        | tdata: code_unit; tuser: first_unit
//  m_axis    | out       | tdata: match_end, found, first_position, position
//  cfg       | in        | write enable, register index, 64-bit write data
//
//  one code unit per cycle while s_tready is high; each result is registered and appears in the cycle after its request
//  a row of cells holds the recent window, one raw unit per cell, and every
//  cell compares its unit with the aligned pattern unit in the request cycle
//  the output register is refilled in the cycle it is drained, so a stalled
//  m_axis only holds s_tready low while an unread result sits there
//  reset clears config, the window, counters and the output valid flag
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module substring_matcher_case_fold #(
    parameter int NEEDLE_MAX    = smcf_pkg::NEEDLE_MAX_DEF,
    parameter int POSITION_BITS = smcf_pkg::POSITION_BITS_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    // slave side
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [smcf_pkg::UNIT_W-1:0]         s_tdata,  // [15:0] code_unit
    input  wire                                 s_tuser,  // [0] first_unit
    // master side
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // [0] match_end, [1] found, [17:2] first_position, [33:18] position,
    // [39:34] zero
    output logic [smcf_pkg::M_TDATA_W-1:0]      m_tdata,
    // configuration
    input  wire                                 cfg_we,
    input  wire  [smcf_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  wire  [smcf_pkg::CFG_DATA_W-1:0]     cfg_data
);

    localparam logic [POSITION_BITS-1:0] POS_LIMIT = {POSITION_BITS{1'b1}};
    localparam int PAD_W = smcf_pkg::M_TDATA_W - smcf_pkg::M_FIELDS_W;
    localparam int UNIT_IDX_W = 4;

    // configuration registers
    logic [smcf_pkg::CFG_DATA_W-1:0] needle_word_reg [smcf_pkg::NEEDLE_WORDS];
    logic [smcf_pkg::LEN_W-1:0]      needle_length_reg;
    logic                            case_fold_reg;

    // haystack state
    logic [POSITION_BITS-1:0]        unit_count_reg, unit_count_next;
    logic                            found_reg, found_next;
    logic [POSITION_BITS-1:0]        first_index_reg, first_index_next;

    // output register
    logic                            m_tvalid_reg;
    logic [smcf_pkg::M_TDATA_W-1:0]  m_tdata_reg;

    logic                            accept;
    logic                            restart;
    logic [smcf_pkg::LEN_W-1:0]      len_eff;
    logic                            empty_pattern;
    logic                            history_ok;
    logic                            match_end;
    logic [POSITION_BITS-1:0]        pos_cur;
    logic                            found_cur;
    logic [POSITION_BITS-1:0]        first_cur;
    smcf_pkg::cell_ctrl_t            cell_ctrl;

    logic [NEEDLE_MAX-1:0]           cell_hit;
    logic [NEEDLE_MAX-1:0]           cell_use;
    logic [smcf_pkg::UNIT_W-1:0]     cell_feed [NEEDLE_MAX];
    logic [smcf_pkg::UNIT_W-1:0]     cell_unit [NEEDLE_MAX];

    // ---------------------------------------------------------------------
    // configuration writes; indexes beyond the list are ignored
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int w = 0; w < smcf_pkg::NEEDLE_WORDS; w++)
            begin
                needle_word_reg[w] <= '0;
            end
            needle_length_reg <= '0;
            case_fold_reg     <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                smcf_pkg::CFG_NEEDLE_WORD_0: needle_word_reg[0] <= cfg_data;
                smcf_pkg::CFG_NEEDLE_WORD_1: needle_word_reg[1] <= cfg_data;
                smcf_pkg::CFG_NEEDLE_WORD_2: needle_word_reg[2] <= cfg_data;
                smcf_pkg::CFG_NEEDLE_WORD_3: needle_word_reg[3] <= cfg_data;
                smcf_pkg::CFG_NEEDLE_LENGTH:
                    needle_length_reg <= cfg_data[smcf_pkg::LEN_W-1:0];
                smcf_pkg::CFG_CASE_FOLD:     case_fold_reg <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // ---------------------------------------------------------------------
    // handshake: take a request whenever the output slot is free or draining
    // ---------------------------------------------------------------------
    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign restart  = s_tuser;

    // lengths above the cell count are clamped to it
    assign len_eff = (needle_length_reg > smcf_pkg::LEN_W'(NEEDLE_MAX))
                   ? smcf_pkg::LEN_W'(NEEDLE_MAX) : needle_length_reg;
    assign empty_pattern = (len_eff == '0);

    assign cell_ctrl.advance   = accept;
    assign cell_ctrl.case_fold = case_fold_reg;

    // ---------------------------------------------------------------------
    // chain of cells: cell k sees window entry k, the newest unit in cell 0,
    // and compares it with pattern unit len - 1 - k
    // ---------------------------------------------------------------------
    for (genvar k = 0; k < NEEDLE_MAX; k++)
    begin : g_cell
        logic [UNIT_IDX_W-1:0]       pat_idx;
        logic [smcf_pkg::UNIT_W-1:0] pat_unit;

        if (k == 0)
        begin : g_head
            assign cell_feed[k] = s_tdata;
        end
        else
        begin : g_link
            assign cell_feed[k] = cell_unit[k-1];
        end

        assign pat_idx  = UNIT_IDX_W'(len_eff - smcf_pkg::LEN_W'(k + 1));
        assign pat_unit = needle_word_reg[pat_idx[UNIT_IDX_W-1:2]]
                              [pat_idx[1:0] * smcf_pkg::UNIT_W +: smcf_pkg::UNIT_W];
        // only positions inside the pattern length take part
        assign cell_use[k] = (smcf_pkg::LEN_W'(k) < len_eff);

        smcf_cell u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctrl         (cell_ctrl),
            .unit_in      (cell_feed[k]),
            .pattern_unit (pat_unit),
            .unit_reg     (cell_unit[k]),
            .hit          (cell_hit[k])
        );
    end

    // ---------------------------------------------------------------------
    // position, found flag and first match index
    // ---------------------------------------------------------------------
    assign pos_cur   = restart ? '0   : unit_count_reg;
    assign found_cur = restart ? 1'b0 : found_reg;
    assign first_cur = restart ? '0   : first_index_reg;

    // enough units in this haystack to hold the whole pattern
    assign history_ok = (({1'b0, pos_cur} + (POSITION_BITS+1)'(1))
                         >= (POSITION_BITS+1)'(len_eff));

    assign match_end = !empty_pattern && history_ok && (&(cell_hit | ~cell_use));

    always_comb
    begin
        unit_count_next = (pos_cur == POS_LIMIT) ? pos_cur
                                                 : pos_cur + POSITION_BITS'(1);
        found_next       = empty_pattern || found_cur || match_end;
        first_index_next = first_cur;
        if (empty_pattern)
        begin
            first_index_next = '0;
        end
        else if (match_end && !found_cur)
        begin
            // match spans len units ending here
            first_index_next = pos_cur - POSITION_BITS'(len_eff) + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            unit_count_reg  <= '0;
            found_reg       <= 1'b0;
            first_index_reg <= '0;
        end
        else if (accept)
        begin
            unit_count_reg  <= unit_count_next;
            found_reg       <= found_next;
            first_index_reg <= first_index_next;
        end
    end

    // ---------------------------------------------------------------------
    // output register
    // ---------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tvalid_reg <= 1'b0;
        end
        else if (accept)
        begin
            m_tvalid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            m_tdata_reg <= {{PAD_W{1'b0}},
                            smcf_pkg::OUT_POS_W'(pos_cur),
                            smcf_pkg::OUT_POS_W'(first_index_next),
                            found_next,
                            match_end};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule

`default_nettype wire

// ===== rtl/smcf_checker.sv =====
// ----------------------------------------------------------------------------
// smcf_checker
// port-level checks for the substring matcher, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "substring_matcher_case_fold_defines.svh"

module smcf_checker (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    input  wire                                 s_tready,
    input  wire                                 s_tuser,
    input  wire                                 m_tvalid,
    input  wire                                 m_tready,
    input  wire  [smcf_pkg::M_TDATA_W-1:0]      m_tdata
);

    // a match ending here always means the haystack has a match
    `SMCF_ASSERT_ALWAYS(a_match_implies_found, clk, rst_n, !m_tvalid || !m_tdata[0] || m_tdata[1])

    // every request yields a result on the next edge
    `SMCF_ASSERT_NEXT(a_request_gives_result, clk, rst_n, s_tvalid && s_tready, m_tvalid)

    // a new haystack starts counting at zero
    `SMCF_ASSERT_NEXT(a_restart_position, clk, rst_n, s_tvalid && s_tready && s_tuser, m_tdata[33:18] == 16'd0)

    // an empty output slot never blocks the input
    `SMCF_ASSERT_ALWAYS(a_ready_when_empty, clk, rst_n, m_tvalid || s_tready)

endmodule

bind substring_matcher_case_fold smcf_checker u_smcf_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
